// ===== design/atcr_pkg.sv =====
// Shared types and constants for the tile collision resolver.
`default_nettype none
package atcr_pkg;

  // Coordinate width inside the datapath (Q16.16 world values plus grid products)
  localparam int CW = 56;
  // Signed width of a cell index from the divider
  localparam int QW = 20;
  // Tile size register width
  localparam int TSW = 16;
  // Stream payload widths
  localparam int IN_DW = 240;
  localparam int OUT_DW = 136;
  localparam int CFG_IW = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_TILE_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 2'd2;

  localparam logic [TSW-1:0] TILE_SIZE_RST = 16'd16;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Divider operand selects
  localparam logic [1:0] SEL_LEFT = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_TOP = 2'd2;
  localparam logic [1:0] SEL_BOTTOM = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic tile_wr;
    logic bounds;
    logic div_start;
    logic div_store;
    logic restore;
    logic mul_x;
    logic mul_y;
    logic scan_init;
    logic rd;
    logic ev1;
    logic ev2;
    logic set_settled;
    logic apply;
    logic out_load;
    logic clr_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_write;
    logic skip;
    logic div_done;
    logic sel_last;
    logic span_bad;
    logic scan_last;
    logic found;
    logic pass_last;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/atcr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module atcr_ram #(
  parameter int W = 1,
  parameter int D = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                    wdata,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                    rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/atcr_div.sv =====
// Bit-serial floor divider of a signed cell coordinate by the tile size.
`default_nettype none
module atcr_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [atcr_pkg::QW-1:0] num,
  input  wire logic [atcr_pkg::TSW-1:0] den,
  output logic                          done,
  output logic signed [atcr_pkg::QW-1:0] quo
);
  import atcr_pkg::*;

  localparam int NW = $clog2(QW + 1);

  logic [QW-1:0]  mag;
  logic [TSW-1:0] rem;
  logic           neg;
  logic           busy;
  logic [NW-1:0]  cnt;
  logic [TSW:0]   rem_sh;
  logic           ge;

  // Restoring step: one quotient bit per cycle
  assign rem_sh = {rem, mag[QW-1]};
  assign ge = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= NW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Negative numerators divide -n + d - 1 so that the result floors
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[QW-1];
      rem <= '0;
      if (num[QW-1]) begin
        mag <= (-num) + QW'(den) - QW'(1);
      end else begin
        mag <= num;
      end
    end else if (busy) begin
      rem <= ge ? TSW'(rem_sh - {1'b0, den}) : rem_sh[TSW-1:0];
      mag <= {mag[QW-2:0], ge};
    end
  end

  assign quo = neg ? -$signed(mag) : $signed(mag);
endmodule
`default_nettype wire

// ===== design/atcr_dp.sv =====
// Datapath: config registers, tile map, bounds, divider, cell scan and push.
`default_nettype none
module atcr_dp #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int MAX_SPAN = 4,
  parameter int PASSES = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [atcr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic [atcr_pkg::IN_DW-1:0]    in_data,
  input  wire logic                          in_user,
  input  wire atcr_pkg::cmd_t                cmd,
  output atcr_pkg::sts_t                     sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [atcr_pkg::OUT_DW-1:0]        out_data
);
  import atcr_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(PASSES + 1);
  localparam int PRW = QW + TSW + 1;

  // Configuration registers
  logic [TSW-1:0]     tile_size;
  logic signed [31:0] org_x;
  logic signed [31:0] org_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size <= TILE_SIZE_RST;
      org_x <= '0;
      org_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_SIZE: tile_size <= cfg_data[TSW-1:0];
        REG_ORIGIN_X:  org_x <= cfg_data;
        REG_ORIGIN_Y:  org_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Best cell of the current pass
  logic                 found, best_axis, best_neg;
  logic signed [CW-1:0] best_pen;

  // Push helpers
  function automatic logic signed [35:0] push_sum(input logic signed [31:0] p);
    logic signed [35:0] pen;
    pen = $signed({2'b00, best_pen[33:0]});
    push_sum = best_neg ? 36'(p) - pen : 36'(p) + pen;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Item registers
  logic               is_write;
  logic [5:0]         wcol;
  logic [5:0]         wrow;
  logic               wbit;
  logic signed [31:0] px, py, vx, vy;
  logic signed [31:0] px0, py0, vx0, vy0;
  logic [30:0]        hx, hy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write <= (in_user == OP_WRITE);
      wcol <= in_data[5:0];
      wrow <= in_data[11:6];
      wbit <= in_data[12];
      px <= in_data[44:13];
      py <= in_data[76:45];
      px0 <= in_data[44:13];
      py0 <= in_data[76:45];
      vx <= in_data[202:171];
      vy <= in_data[234:203];
      vx0 <= in_data[202:171];
      vy0 <= in_data[234:203];
      hx <= in_data[170] ? in_data[169:139] : in_data[107:77];
      hy <= in_data[170] ? in_data[169:139] : in_data[138:108];
    end else if (cmd.restore) begin
      px <= px0;
      py <= py0;
      vx <= vx0;
      vy <= vy0;
    end else if (cmd.apply) begin
      if (!best_axis) begin
        px <= sat32(push_sum(px));
        if ((best_neg && vx > 0) || (!best_neg && vx < 0)) begin
          vx <= '0;
        end
      end else begin
        py <= sat32(push_sum(py));
        if ((best_neg && vy > 0) || (!best_neg && vy < 0)) begin
          vy <= '0;
        end
      end
    end
  end

  // Tile size and coordinates widened for the datapath
  logic signed [CW-1:0] ts_c, half_c, orgx_c, orgy_c;
  assign ts_c = $signed({{(CW-TSW-16){1'b0}}, tile_size, 16'b0});
  assign half_c = $signed({{(CW-TSW-15){1'b0}}, tile_size, 15'b0});
  assign orgx_c = CW'(org_x);
  assign orgy_c = CW'(org_y);

  // Entity bounds for the current pass
  logic signed [CW-1:0] left, right, top, bottom;
  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      left <= CW'(px) - $signed({{(CW-31){1'b0}}, hx});
      right <= CW'(px) + $signed({{(CW-31){1'b0}}, hx});
      top <= CW'(py) - $signed({{(CW-31){1'b0}}, hy});
      bottom <= CW'(py) + $signed({{(CW-31){1'b0}}, hy});
    end
  end

  // Cell index of each edge: floor((edge - origin) / ts), done as (>>> 16) / tile_size
  logic [1:0]           sel;
  logic signed [CW-1:0] div_diff;
  logic signed [QW-1:0] div_num, div_quo;
  logic                 div_done;
  logic signed [QW-1:0] c0, c1, r0, r1;

  always_comb begin
    case (sel)
      SEL_LEFT:   div_diff = left - orgx_c;
      SEL_RIGHT:  div_diff = right - orgx_c;
      SEL_TOP:    div_diff = top - orgy_c;
      SEL_BOTTOM: div_diff = bottom - orgy_c;
      default:    div_diff = '0;
    endcase
  end
  assign div_num = div_diff[QW+15:16];

  atcr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (tile_size),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      sel <= SEL_LEFT;
    end else if (cmd.div_store) begin
      sel <= sel + 1'b1;
      case (sel)
        SEL_LEFT:   c0 <= div_quo;
        SEL_RIGHT:  c1 <= div_quo;
        SEL_TOP:    r0 <= div_quo;
        SEL_BOTTOM: r1 <= div_quo;
        default: ;
      endcase
    end
  end

  // Span check
  logic signed [QW:0] span_c, span_r;
  assign span_c = (QW+1)'(c1) - (QW+1)'(c0);
  assign span_r = (QW+1)'(r1) - (QW+1)'(r0);

  // Grid corner of the first covered cell, one shared multiplier
  logic signed [PRW-1:0] prod;
  logic signed [CW-1:0]  prod_w;
  logic signed [CW-1:0]  base_x;
  assign prod_w = $signed({{(CW-PRW-16){prod[PRW-1]}}, prod, 16'b0});

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= PRW'((cmd.mul_y ? r0 : c0) * $signed({1'b0, tile_size}));
    end
    if (cmd.mul_y) begin
      base_x <= orgx_c + prod_w;
    end
  end

  // Cell scan registers
  logic signed [QW-1:0] cur_c, cur_r;
  logic signed [CW-1:0] cur_tl, cur_tt;
  logic                 ingrid_q, solid_q;
  logic signed [CW-1:0] ox, oy;
  logic                 negx, negy;
  logic                 in_grid;
  logic [AW-1:0]        raddr;
  logic [0:0]           rdata;

  assign in_grid = (cur_c >= 0) && (cur_c < $signed(QW'(GRID_COLS)))
                && (cur_r >= 0) && (cur_r < $signed(QW'(GRID_ROWS)));
  assign raddr = AW'(unsigned'(cur_r)) * AW'(GRID_COLS) + AW'(unsigned'(cur_c));
  assign sts.scan_last = (cur_c == c1) && (cur_r == r1);

  // Overlap of the entity with the current cell
  logic signed [CW-1:0] tr, tb, ox_c, oy_c;
  assign tr = cur_tl + ts_c;
  assign tb = cur_tt + ts_c;
  assign ox_c = ((right < tr) ? right : tr) - ((left > cur_tl) ? left : cur_tl);
  assign oy_c = ((bottom < tb) ? bottom : tb) - ((top > cur_tt) ? top : cur_tt);

  logic hit;
  assign hit = solid_q && (ox > 0) && (oy > 0);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cur_c <= c0;
      cur_r <= r0;
      cur_tl <= base_x;
      cur_tt <= orgy_c + prod_w;
      found <= 1'b0;
    end
    if (cmd.rd) begin
      ingrid_q <= in_grid;
    end
    if (cmd.ev1) begin
      solid_q <= rdata[0] && ingrid_q;
      ox <= ox_c;
      oy <= oy_c;
      negx <= CW'(px) < cur_tl + half_c;
      negy <= CW'(py) < cur_tt + half_c;
    end
    if (cmd.ev2) begin
      // Shallower axis wins, vertical on a tie; first cell wins ties between cells
      if (hit) begin
        if (ox < oy) begin
          if (!found || ox < best_pen) begin
            found <= 1'b1;
            best_pen <= ox;
            best_axis <= 1'b0;
            best_neg <= negx;
          end
        end else if (!found || oy < best_pen) begin
          found <= 1'b1;
          best_pen <= oy;
          best_axis <= 1'b1;
          best_neg <= negy;
        end
      end
      // Row-major advance
      if (cur_c == c1) begin
        cur_c <= c0;
        cur_tl <= base_x;
        cur_r <= cur_r + 1'b1;
        cur_tt <= cur_tt + ts_c;
      end else begin
        cur_c <= cur_c + 1'b1;
        cur_tl <= cur_tl + ts_c;
      end
    end
  end

  // Pass count and result flags
  logic [PW-1:0] pass_cnt;
  logic          settled, too_large;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pass_cnt <= '0;
      settled <= 1'b0;
      too_large <= 1'b0;
    end else begin
      if (cmd.apply) begin
        pass_cnt <= pass_cnt + 1'b1;
      end
      if (cmd.restore) begin
        too_large <= 1'b1;
      end
      if (cmd.set_settled) begin
        settled <= 1'b1;
      end
    end
  end

  // Tile map with clearing sweep after reset
  logic [AW:0]   clr_cnt;
  logic          wr_in_grid;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;

  assign wr_in_grid = (32'(wcol) < GRID_COLS) && (32'(wrow) < GRID_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    if (cmd.clr_step) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt[AW-1:0];
      ram_wdata = 1'b0;
    end else begin
      ram_we = cmd.tile_wr && wr_in_grid;
      ram_waddr = AW'(wrow) * AW'(GRID_COLS) + AW'(wcol);
      ram_wdata = wbit;
    end
  end

  atcr_ram #(.W(1), .D(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_write) begin
        out_data <= '0;
      end else begin
        out_data <= {6'b0, too_large, settled, vy, vx, py, px};
      end
    end
  end

  // Status to controller
  assign sts.is_write = is_write;
  assign sts.skip = (tile_size == '0) || (hx == '0) || (hy == '0);
  assign sts.div_done = div_done;
  assign sts.sel_last = (sel == SEL_BOTTOM);
  assign sts.span_bad = (span_c >= $signed((QW+1)'(MAX_SPAN)))
                     || (span_r >= $signed((QW+1)'(MAX_SPAN)));
  assign sts.found = found;
  assign sts.pass_last = (pass_cnt == PW'(PASSES - 1));
  assign sts.clr_done = (clr_cnt == (AW+1)'(DEPTH - 1));
  assign sts.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

// ===== design/atcr_ctrl.sv =====
// Controller state machine sequencing passes, divisions and the cell scan.
`default_nettype none
module atcr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire atcr_pkg::sts_t sts,
  output atcr_pkg::cmd_t      cmd
);
  import atcr_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_DECIDE   = 15'b000000000000100,
    S_BOUNDS   = 15'b000000000001000,
    S_DIV_GO   = 15'b000000000010000,
    S_DIV_WAIT = 15'b000000000100000,
    S_SPAN     = 15'b000000001000000,
    S_MUL_X    = 15'b000000010000000,
    S_MUL_Y    = 15'b000000100000000,
    S_INIT     = 15'b000001000000000,
    S_RD       = 15'b000010000000000,
    S_EV1      = 15'b000100000000000,
    S_EV2      = 15'b001000000000000,
    S_PEND     = 15'b010000000000000,
    S_FINISH   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_write) begin
          cmd.tile_wr = 1'b1;
          state_next = S_FINISH;
        end else if (sts.skip) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_BOUNDS;
        end
      end
      S_BOUNDS: begin
        cmd.bounds = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next = sts.sel_last ? S_SPAN : S_DIV_GO;
        end
      end
      S_SPAN: begin
        if (sts.span_bad) begin
          cmd.restore = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.mul_x = 1'b1;
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul_y = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_EV1;
      end
      S_EV1: begin
        cmd.ev1 = 1'b1;
        state_next = S_EV2;
      end
      S_EV2: begin
        cmd.ev2 = 1'b1;
        state_next = sts.scan_last ? S_PEND : S_RD;
      end
      S_PEND: begin
        if (!sts.found) begin
          cmd.set_settled = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.apply = 1'b1;
          state_next = sts.pass_last ? S_FINISH : S_BOUNDS;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/aabb_tile_collision_resolve_core.sv =====
// Top level of the tile map collision resolver.
`default_nettype none
// Keeps a GRID_COLS x GRID_ROWS solid-tile bitmap and pushes a box or circle
// out of solid tiles, one item at a time. After reset the map is swept clear,
// one tile per cycle, during which no item is taken. A tile write is decoded
// and written straight to the map. A resolve item is loaded and decoded, then
// each of up to PASSES passes computes the bounds, runs the four bit-serial
// floor divisions by the tile size and the cell corner products, and scans
// each covered cell with a tile map read and the overlap test.
// The next item is taken while a finished result waits in the output register.
module aabb_tile_collision_resolve_core #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int MAX_SPAN = 4,
  parameter int PASSES = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [atcr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tile_col, tile_row, solid_bit, pos_x, pos_y, half_x, half_y, radius,
  // round_shape, vel_x, vel_y
  input  wire logic [atcr_pkg::IN_DW-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, settled, span_too_large
  output logic [atcr_pkg::OUT_DW-1:0]      m_axis_tdata
);
  import atcr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  atcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atcr_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .MAX_SPAN  (MAX_SPAN),
    .PASSES    (PASSES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  assign s_axis_tready = in_ready;

  // Both result flags never come together
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[128] && m_axis_tdata[129]))
    else $error("settled and span flag both set");

  // The map clear keeps input closed right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input open during map clear");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule
`default_nettype wire
